FILE: sv/pbrlm_pkg.sv
`default_nettype none

package pbrlm_pkg;

    localparam int LANES_DEF      = 8;
    localparam int COUNT_BITS_DEF = 32;
    localparam int QUEUE_DEPTH    = 2;

    localparam int MIN_W  = 10;
    localparam int OUT_W  = 32;
    localparam int POS_W  = 3;
    localparam int BYTE_W = 8;

    localparam logic [MIN_W-1:0] MIN_RUN_RESET = 10'd18;
    localparam logic [MIN_W-1:0] MIN_RUN_FLOOR = 10'd2;

    localparam logic KIND_RUN     = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

`default_nettype wire

FILE: sv/pbrlm_front.sv
`default_nettype none

module pbrlm_front
    import pbrlm_pkg::*;
#(
    parameter int LANES      = LANES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    localparam int ENTRY_W   = LANES * (2 + 2 * COUNT_BITS) + 1
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [BYTE_W-1:0]   data_byte,
    input  wire logic                end_of_stream,
    input  wire logic [MIN_W-1:0]    min_run_length,
    input  wire fifo_stat_t          stat,
    output logic                     push,
    output logic [ENTRY_W-1:0]       entry
);

    localparam int CB       = COUNT_BITS;
    localparam int LEN_LO   = 2 * LANES + 1;
    localparam int START_LO = LEN_LO + LANES * CB;

    logic                  value_reg  [LANES];
    logic [CB-1:0]         len_reg    [LANES];
    logic [CB-1:0]         start_reg  [LANES];
    logic [CB-1:0]         offset_reg;

    logic                  value_next [LANES];
    logic [CB-1:0]         len_next   [LANES];
    logic [CB-1:0]         start_next [LANES];
    logic [CB-1:0]         offset_next;

    logic [LANES+BYTE_W-1:0] padded;
    logic [CB-1:0]           minlen;
    logic [LANES-1:0]        report;
    logic                    accept;

    assign in_ready = !stat.full;
    assign accept   = in_valid && in_ready;
    assign padded   = {{LANES{1'b0}}, data_byte};
    assign minlen   = (min_run_length < MIN_RUN_FLOOR) ? CB'(MIN_RUN_FLOOR)
                                                       : CB'(min_run_length);

    always_comb
    begin
        logic          bit_in;
        logic          cont;
        logic          ended;
        logic          flush;
        logic          upd_val;
        logic [CB-1:0] upd_len;
        logic [CB-1:0] upd_start;

        entry               = '0;
        entry[LANES]        = end_of_stream;
        for (int b = 0; b < LANES; b++)
        begin
            bit_in    = padded[b];
            cont      = (len_reg[b] != '0) && (bit_in == value_reg[b]);
            ended     = !cont && (len_reg[b] >= minlen);
            upd_val   = cont ? value_reg[b] : bit_in;
            upd_len   = cont ? ((len_reg[b] == '1) ? len_reg[b] : len_reg[b] + CB'(1))
                             : CB'(1);
            upd_start = cont ? start_reg[b] : offset_reg;
            flush     = end_of_stream && (upd_len >= minlen);

            report[b]                       = ended || flush;
            entry[b]                        = ended || flush;
            entry[LANES + 1 + b]            = ended ? value_reg[b] : upd_val;
            entry[LEN_LO + b * CB +: CB]    = ended ? len_reg[b] : upd_len;
            entry[START_LO + b * CB +: CB]  = ended ? start_reg[b] : upd_start;

            // clear for the next stream after the final byte
            value_next[b] = end_of_stream ? 1'b0 : upd_val;
            len_next[b]   = end_of_stream ? '0 : upd_len;
            start_next[b] = end_of_stream ? '0 : upd_start;
        end
        offset_next = end_of_stream ? '0
                    : ((offset_reg == '1) ? offset_reg : offset_reg + CB'(1));
    end

    // drop bytes that cause no result
    assign push = accept && ((|report) || end_of_stream);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < LANES; b++)
            begin
                value_reg[b] <= 1'b0;
                len_reg[b]   <= '0;
                start_reg[b] <= '0;
            end
            offset_reg <= '0;
        end
        else if (accept)
        begin
            for (int b = 0; b < LANES; b++)
            begin
                value_reg[b] <= value_next[b];
                len_reg[b]   <= len_next[b];
                start_reg[b] <= start_next[b];
            end
            offset_reg <= offset_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/pbrlm_queue.sv
`default_nettype none

module pbrlm_queue
    import pbrlm_pkg::*;
#(
    parameter int WIDTH = 1
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rd_data,
    output fifo_stat_t            stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign rd_data    = mem[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/pbrlm_back.sv
`default_nettype none

module pbrlm_back
    import pbrlm_pkg::*;
#(
    parameter int LANES      = LANES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    localparam int ENTRY_W   = LANES * (2 + 2 * COUNT_BITS) + 1
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire fifo_stat_t         stat,
    input  wire logic [ENTRY_W-1:0] head,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    report_kind,
    output logic [POS_W-1:0]        bit_position,
    output logic                    bit_value,
    output logic [OUT_W-1:0]        run_length,
    output logic [OUT_W-1:0]        start_offset,
    output logic [OUT_W-1:0]        groups_total,
    output logic                    last_result
);

    localparam int CB       = COUNT_BITS;
    localparam int LANE_W   = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int LEN_LO   = 2 * LANES + 1;
    localparam int START_LO = LEN_LO + LANES * CB;

    function automatic logic [OUT_W-1:0] clip(input logic [CB-1:0] v);
        logic [CB+OUT_W-1:0] ext;
        ext = {{OUT_W{1'b0}}, v};
        return (|ext[CB+OUT_W-1:OUT_W]) ? '1 : ext[OUT_W-1:0];
    endfunction

    logic [LANES-1:0]  sent_reg, sent_next;
    logic [CB-1:0]     group_reg, group_next;
    logic              valid_reg, valid_next;
    logic              kind_reg, kind_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              val_reg, val_next;
    logic [OUT_W-1:0]  len_reg, len_next;
    logic [OUT_W-1:0]  start_reg, start_next;
    logic [OUT_W-1:0]  total_reg, total_next;
    logic              last_reg, last_next;

    logic [LANES-1:0]  pending;
    logic              has_pend;
    logic              single;
    logic              head_last;
    logic [LANE_W-1:0] idx;
    logic              load;

    assign head_last = head[LANES];
    assign pending   = head[LANES-1:0] & ~sent_reg;
    assign has_pend  = |pending;
    assign single    = has_pend && ((pending & (pending - LANES'(1))) == '0);

    always_comb
    begin
        idx = '0;
        for (int i = LANES - 1; i >= 0; i--)
        begin
            if (pending[i])
            begin
                idx = LANE_W'(i);
            end
        end
    end

    // advance when the output register is free or being taken
    assign load = !stat.empty && (!valid_reg || out_ready);
    assign pop  = load && (has_pend ? (single && !head_last) : 1'b1);

    always_comb
    begin
        sent_next  = sent_reg;
        group_next = group_reg;
        valid_next = out_ready ? 1'b0 : valid_reg;
        kind_next  = kind_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        len_next   = len_reg;
        start_next = start_reg;
        total_next = total_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = has_pend || head_last;
            if (has_pend)
            begin
                kind_next  = KIND_RUN;
                pos_next   = POS_W'(idx);
                val_next   = head[LANES + 1 + idx];
                len_next   = clip(head[LEN_LO + idx * CB +: CB]);
                start_next = clip(head[START_LO + idx * CB +: CB]);
                total_next = '0;
                last_next  = single && !head_last;
                group_next = (group_reg == '1) ? group_reg : group_reg + CB'(1);
                sent_next  = sent_reg | (LANES'(1) << idx);
            end
            else
            begin
                kind_next  = KIND_SUMMARY;
                pos_next   = '0;
                val_next   = 1'b0;
                len_next   = '0;
                start_next = '0;
                total_next = clip(group_reg);
                last_next  = 1'b1;
                group_next = '0;
            end
            if (pop)
            begin
                sent_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg  <= '0;
            group_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sent_reg  <= sent_next;
            group_reg <= group_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        len_reg   <= len_next;
        start_reg <= start_next;
        total_reg <= total_next;
        last_reg  <= last_next;
    end

    assign out_valid    = valid_reg;
    assign report_kind  = kind_reg;
    assign bit_position = pos_reg;
    assign bit_value    = val_reg;
    assign run_length   = len_reg;
    assign start_offset = start_reg;
    assign groups_total = total_reg;
    assign last_result  = last_reg;

endmodule

`default_nettype wire

FILE: sv/per_bit_run_length_monitor_unit.sv
// Per-lane run length monitor. Each byte taken on the input channel feeds one bit to
// every lane; a lane reports a run of equal bits once it ends with a length of at
// least min_run_length (values below 2 act as 2), and the byte flagged end_of_stream
// flushes every open qualifying run, then yields a summary with the group total and
// clears all lane state. The front end classifies one byte per cycle while the queue
// has room and queues the bytes that cause results (two entries deep); the back end
// sends one result per cycle unless stalled, lanes in ascending order, summary last.
// A byte with no result is not queued; a byte with k results holds the back end until
// all k are sent, so sustained input rate is one byte per cycle while reports stay
// sparse. A result moves through a queue entry to the output register. min_run_length
// may be written at any time the block is idle; cfg_ready is always high.
`default_nettype none

module per_bit_run_length_monitor_unit
    import pbrlm_pkg::*;
#(
    parameter int LANES      = LANES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [MIN_W-1:0]  cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire logic              end_of_stream,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   report_kind,
    output logic [POS_W-1:0]       bit_position,
    output logic                   bit_value,
    output logic [OUT_W-1:0]       run_length,
    output logic [OUT_W-1:0]       start_offset,
    output logic [OUT_W-1:0]       groups_total,
    output logic                   last_result
);

    localparam int ENTRY_W = LANES * (2 + 2 * COUNT_BITS) + 1;

    logic [MIN_W-1:0]   min_reg;
    fifo_stat_t         stat;
    logic               push;
    logic               pop;
    logic [ENTRY_W-1:0] entry;
    logic [ENTRY_W-1:0] head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_RUN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            min_reg <= cfg_data;
        end
    end

    pbrlm_front #(
        .LANES      (LANES),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .end_of_stream  (end_of_stream),
        .min_run_length (min_reg),
        .stat           (stat),
        .push           (push),
        .entry          (entry)
    );

    pbrlm_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (entry),
        .pop     (pop),
        .rd_data (head),
        .stat    (stat)
    );

    pbrlm_back #(
        .LANES      (LANES),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .stat         (stat),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .report_kind  (report_kind),
        .bit_position (bit_position),
        .bit_value    (bit_value),
        .run_length   (run_length),
        .start_offset (start_offset),
        .groups_total (groups_total),
        .last_result  (last_result)
    );

endmodule

`default_nettype wire

FILE: sv/pbrlm_checker.sv
`default_nettype none

module pbrlm_checker
    import pbrlm_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic              report_kind,
    input wire logic [POS_W-1:0]  bit_position,
    input wire logic              bit_value,
    input wire logic [OUT_W-1:0]  run_length,
    input wire logic [OUT_W-1:0]  start_offset,
    input wire logic [OUT_W-1:0]  groups_total,
    input wire logic              last_result
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(report_kind)
            && $stable(bit_position) && $stable(run_length) && $stable(last_result))
        else $error("stalled result changed");

    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && report_kind == KIND_SUMMARY |-> last_result)
        else $error("summary without last_result");

    a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && report_kind == KIND_SUMMARY |-> bit_position == '0
            && !bit_value && run_length == '0 && start_offset == '0)
        else $error("summary carries run fields");

    a_run_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && report_kind == KIND_RUN |-> groups_total == '0
            && run_length >= OUT_W'(MIN_RUN_FLOOR))
        else $error("run report malformed");

endmodule

bind per_bit_run_length_monitor_unit pbrlm_checker u_pbrlm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .report_kind  (report_kind),
    .bit_position (bit_position),
    .bit_value    (bit_value),
    .run_length   (run_length),
    .start_offset (start_offset),
    .groups_total (groups_total),
    .last_result  (last_result)
);

`default_nettype wire

FILE: sim/per_bit_run_length_monitor_unit_test.sv
`timescale 1ns / 1ps

module per_bit_run_length_monitor_unit_test;
    import pbrlm_pkg::*;

    typedef struct packed {
        logic              kind;
        logic [POS_W-1:0]  lane;
        logic              value;
        logic [OUT_W-1:0]  len;
        logic [OUT_W-1:0]  start_off;
        logic [OUT_W-1:0]  total;
        logic              last_res;
    } run_report_t;

    // Tracks every lane's open run and predicts the reports each byte causes.
    class lane_run_tracker;
        logic [MIN_W-1:0] min_run;
        logic             lane_bit[LANES_DEF];
        logic [OUT_W-1:0] lane_len[LANES_DEF];
        logic [OUT_W-1:0] lane_start[LANES_DEF];
        logic [OUT_W-1:0] offset;
        logic [OUT_W-1:0] groups;
        run_report_t      due_reports[$];
        int               streams;

        function new();
            min_run = MIN_RUN_RESET;
            streams = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            for (int b = 0; b < LANES_DEF; b++)
            begin
                lane_bit[b]   = 1'b0;
                lane_len[b]   = '0;
                lane_start[b] = '0;
            end
            offset = '0;
            groups = '0;
        endfunction

        function logic [OUT_W-1:0] sat_inc(input logic [OUT_W-1:0] v);
            return (v == '1) ? v : v + 1'b1;
        endfunction

        function run_report_t lane_report(input int b);
            run_report_t r;
            r           = '0;
            r.kind      = KIND_RUN;
            r.lane      = b[POS_W-1:0];
            r.value     = lane_bit[b];
            r.len       = lane_len[b];
            r.start_off = lane_start[b];
            return r;
        endfunction

        function void take_byte(input logic [BYTE_W-1:0] d, input logic eos);
            run_report_t      made[$];
            run_report_t      r;
            logic [OUT_W-1:0] minlen;
            minlen = OUT_W'(min_run);
            if (min_run < MIN_RUN_FLOOR)
                minlen = OUT_W'(MIN_RUN_FLOOR);
            for (int b = 0; b < LANES_DEF; b++)
            begin
                if (lane_len[b] != 0 && d[b] == lane_bit[b])
                    lane_len[b] = sat_inc(lane_len[b]);
                else
                begin
                    if (lane_len[b] >= minlen)
                    begin
                        made.push_back(lane_report(b));
                        groups = sat_inc(groups);
                    end
                    lane_bit[b]   = d[b];
                    lane_len[b]   = 1;
                    lane_start[b] = offset;
                end
                // flush the open run on the final byte
                if (eos && lane_len[b] >= minlen)
                begin
                    made.push_back(lane_report(b));
                    groups = sat_inc(groups);
                end
            end
            offset = sat_inc(offset);
            if (eos)
            begin
                r       = '0;
                r.kind  = KIND_SUMMARY;
                r.total = groups;
                made.push_back(r);
                clear_stream();
                streams++;
            end
            for (int i = 0; i < made.size(); i++)
            begin
                r          = made[i];
                r.last_res = (i == made.size() - 1);
                due_reports.push_back(r);
            end
        endfunction

        function bit check_report(input run_report_t got, output string msg);
            run_report_t want;
            string       diff;
            if (due_reports.size() == 0)
            begin
                msg = $sformatf("result with nothing pending: kind %0d lane %0d len %0d",
                                got.kind, got.lane, got.len);
                return 1'b0;
            end
            want = due_reports.pop_front();
            diff = "";
            if (got.kind !== want.kind)
                diff = {diff, $sformatf(" kind %0d/%0d", got.kind, want.kind)};
            if (got.lane !== want.lane)
                diff = {diff, $sformatf(" lane %0d/%0d", got.lane, want.lane)};
            if (got.value !== want.value)
                diff = {diff, $sformatf(" value %0d/%0d", got.value, want.value)};
            if (got.len !== want.len)
                diff = {diff, $sformatf(" run_length %0d/%0d", got.len, want.len)};
            if (got.start_off !== want.start_off)
                diff = {diff, $sformatf(" start_offset %0d/%0d", got.start_off,
                                        want.start_off)};
            if (got.total !== want.total)
                diff = {diff, $sformatf(" groups_total %0d/%0d", got.total, want.total)};
            if (got.last_res !== want.last_res)
                diff = {diff, $sformatf(" last_result %0d/%0d", got.last_res,
                                        want.last_res)};
            msg = {"field mismatch (got/want):", diff};
            return diff == "";
        endfunction

        function int pending();
            return due_reports.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [MIN_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_stream;
    logic              out_valid;
    logic              out_ready;
    logic              report_kind;
    logic [POS_W-1:0]  bit_position;
    logic              bit_value;
    logic [OUT_W-1:0]  run_length;
    logic [OUT_W-1:0]  start_offset;
    logic [OUT_W-1:0]  groups_total;
    logic              last_result;

    lane_run_tracker tracker;
    int errors;
    int bytes_sent;
    int runs_seen;
    int summaries_seen;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_ticket;
    int hold_served;
    int hold_left;
    logic [MIN_W-1:0] mid_min;
    logic [MIN_W-1:0] late_min;

    per_bit_run_length_monitor_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .report_kind   (report_kind),
        .bit_position  (bit_position),
        .bit_value     (bit_value),
        .run_length    (run_length),
        .start_offset  (start_offset),
        .groups_total  (groups_total),
        .last_result   (last_result)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report_mismatch(input string what);
        errors++;
        $display("ERROR at %0t: %s", $time, what);
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_ticket != hold_served)
        begin
            hold_served = hold_ticket;
            hold_left   = 80;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        run_report_t got;
        string       msg;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{report_kind, bit_position, bit_value, run_length, start_offset,
                    groups_total, last_result};
            if (got.kind == KIND_SUMMARY)
                summaries_seen++;
            else
                runs_seen++;
            if (!tracker.check_report(got, msg))
                report_mismatch(msg);
        end
    end

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] d, input logic eos);
        int gap;
        gap = 0;
        while (gap < 12 && $urandom_range(99) < send_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= d;
        end_of_stream <= eos;
        do @(posedge clk); while (!in_ready);
        tracker.take_byte(d, eos);
        bytes_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_min_run(input logic [MIN_W-1:0] v);
        drain_results();
        // bytes with no report may still be in flight
        repeat (8) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        tracker.min_run = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly whole streams of slowly changing bytes, so lanes build long runs;
    // the rest is raw noise with a stray end marker now and then.
    task automatic send_streams(input int n_items, input int flip_max);
        int               sent;
        int               len;
        int               flip;
        logic [BYTE_W-1:0] b;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 80)
            begin
                len  = ($urandom_range(9) == 0) ? $urandom_range(30, 70)
                                                : $urandom_range(1, 25);
                flip = $urandom_range(0, flip_max);
                b    = BYTE_W'($urandom_range(255));
                for (int i = 0; i < len; i++)
                begin
                    send_byte(b, i == len - 1);
                    for (int k = 0; k < BYTE_W; k++)
                        if ($urandom_range(99) < flip)
                            b[k] = ~b[k];
                end
                sent += len;
            end
            else
            begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                    send_byte(BYTE_W'($urandom_range(255)), $urandom_range(7) == 0);
                sent += len;
            end
        end
    endtask

    initial
    begin
        tracker        = new();
        errors         = 0;
        bytes_sent     = 0;
        runs_seen      = 0;
        summaries_seen = 0;
        hold_ticket    = 0;
        hold_served    = 0;
        hold_left      = 0;
        set_idling(0, 0);
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        data_byte     = '0;
        end_of_stream = 1'b0;
        out_ready     = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset minimum, no idling
        send_streams(35, 6);

        // directed: zero minimum acts as two
        write_min_run(10'd0);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h3C, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h0F, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h01, 1'b1);

        write_min_run(10'd1);
        set_idling(61, 0);
        send_streams(35, 30);

        write_min_run(MIN_RUN_FLOOR);
        set_idling(0, 61);
        send_streams(35, 40);
        // hold the receiver while pairs of bytes keep ending runs in every lane
        hold_ticket++;
        for (int i = 0; i < 24; i++)
            send_byte(i[1] ? 8'hFF : 8'h00, i == 23);

        mid_min = MIN_W'($urandom_range(3, 12));
        write_min_run(mid_min);
        set_idling(9, 9);
        send_streams(20, 25);
        drain_results();
        send_streams(20, 25);

        // top of the range: nothing in a short stream can qualify
        write_min_run(10'd1023);
        set_idling(0, 0);
        for (int i = 0; i < 30; i++)
            send_byte((i < 24) ? 8'h5A : 8'h55, i == 29);

        write_min_run(10'd1000);
        set_idling(0, 61);
        send_streams(15, 10);

        late_min = MIN_W'($urandom_range(2, 40));
        write_min_run(late_min);
        set_idling(0, 0);
        send_streams(12, 8);
        set_idling(61, 0);
        send_streams(12, 8);
        set_idling(0, 61);
        send_streams(12, 8);
        set_idling(9, 9);
        send_streams(12, 8);

        drain_results();
        repeat (20) @(posedge clk);
        if (tracker.pending() != 0)
            report_mismatch($sformatf("%0d results never arrived", tracker.pending()));
        $display("covered %0d bytes in %0d streams; checked %0d run reports, %0d summaries",
                 bytes_sent, tracker.streams, runs_seen, summaries_seen);
        $display("minimum run settings: 18 0 1 2 %0d 1023 1000 %0d; long receiver hold-off",
                 mid_min, late_min);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d results outstanding", tracker.pending());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
